// ===== rtl/frrm_pkg.sv =====
// ----------------------------------------------------------------------------
// frrm_pkg
// Shared types, codes and defaults of the flash record ring manager.
// ----------------------------------------------------------------------------
package frrm_pkg;

   localparam int SLOT_COUNT_DEF       = 4096;
   localparam int SLOTS_PER_SECTOR_DEF = 16;

   localparam logic [2:0] OPC_PUSH   = 3'd0;
   localparam logic [2:0] OPC_PEEK   = 3'd1;
   localparam logic [2:0] OPC_MARK   = 3'd2;
   localparam logic [2:0] OPC_FORMAT = 3'd3;
   localparam logic [2:0] OPC_RESCAN = 3'd4;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_FOUND    = 2'd1;
   localparam logic [1:0] ST_NONE     = 2'd2;
   localparam logic [1:0] ST_DISABLED = 2'd3;

   localparam logic [1:0] FLAG_EMPTY = 2'd0;
   localparam logic [1:0] FLAG_VALID = 2'd1;
   localparam logic [1:0] FLAG_SENT  = 2'd2;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [11:0] slot_to_mark;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] slot_index;
      logic [31:0] record_sequence;
      logic [4:0]  lost_records;
      logic [12:0] pending_count;
      logic [11:0] read_pointer;
      logic [11:0] write_pointer;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LATCH,
      OP_CLEAR_INIT,
      OP_CLEAR_STEP,
      OP_FORMAT,
      OP_RES_DISABLED,
      OP_RES_NONE,
      OP_PUSH_INIT,
      OP_STEP,
      OP_PUSH_WRITE,
      OP_SEC_INIT,
      OP_SEC_STEP,
      OP_ERASE_INIT,
      OP_ERASE_STEP,
      OP_ERASE_FIX,
      OP_RPTR_FOUND,
      OP_ADDR_WR,
      OP_PEEK_INIT,
      OP_PEEK_FOUND,
      OP_PEEK_MISS,
      OP_MARK,
      OP_SCAN_INIT,
      OP_SCAN_STEP,
      OP_SCAN_FIN,
      OP_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic       enabled;
      logic [2:0] opcode;
      logic       mark_ok;
      logic       total_zero;
      logic       flag_free;
      logic       flag_valid;
      logic       walk_last;
      logic       erase_last;
      logic       sec_below;
   } sts_type;

endpackage

// ===== rtl/flash_record_ring_manager.sv =====
// ----------------------------------------------------------------------------
// flash_record_ring_manager
// Circular record log over a ring of slots with erase sectors.
//
//   Port group   Direction   Carries
//   req_*        in          one operation word (opcode, slot to mark)
//   rsp_*        out         one result word per operation
//   csr_*        in          store enable register write
//
// One operation at a time. Each slot visited by a push, peek, erase or rescan walk
// passes a registered memory read and then an evaluation. A push on a full ring or
// a peek that misses makes up to two walks of the ring, a push also searching and
// erasing a sector. After reset the flag memory is cleared before req_ready rises.
// A waiting result in the output register does not block acceptance.
// ----------------------------------------------------------------------------
module flash_record_ring_manager import frrm_pkg::*; #(
   parameter int SLOT_COUNT       = SLOT_COUNT_DEF,
   parameter int SLOTS_PER_SECTOR = SLOTS_PER_SECTOR_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   frrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   frrm_datapath #(
      .SLOT_COUNT       (SLOT_COUNT),
      .SLOTS_PER_SECTOR (SLOTS_PER_SECTOR)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== rtl/frrm_datapath.sv =====
// ----------------------------------------------------------------------------
// frrm_datapath
// Slot memories, pointers, counters, scan accumulators and result register.
// ----------------------------------------------------------------------------
module frrm_datapath import frrm_pkg::*; #(
   parameter int SLOT_COUNT       = SLOT_COUNT_DEF,
   parameter int SLOTS_PER_SECTOR = SLOTS_PER_SECTOR_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data,
   output rsp_type rsp_data
);

   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int TOT_W  = $clog2(SLOT_COUNT + 1);
   localparam int SEC_W  = IDX_W + 1;
   localparam int LOST_W = $clog2(SLOTS_PER_SECTOR + 1);

   logic [1:0]  flags_mem [SLOT_COUNT];
   logic [31:0] seqs_mem  [SLOT_COUNT];

   logic             enabled_ff;
   logic [2:0]       opcode_ff;
   logic [11:0]      mark_ff;
   logic [IDX_W-1:0] rd_ptr_ff, wr_ptr_ff, addr_ff, cnt_ff;
   logic [TOT_W-1:0] total_ff;
   logic [31:0]      next_seq_ff;
   logic [1:0]       flag_q_ff;
   logic [31:0]      seq_q_ff;
   logic [SEC_W-1:0] sec_base_ff;
   logic [LOST_W-1:0] lost_ff;
   logic [TOT_W-1:0] vcount_ff;
   logic             have_valid_ff, have_free_ff;
   logic [IDX_W-1:0] first_free_ff, min_idx_ff, max_idx_ff;
   logic [31:0]      min_seq_ff, max_seq_ff;
   logic [1:0]       res_status_ff;
   logic [IDX_W-1:0] res_slot_ff;
   logic [31:0]      res_seq_ff;
   logic [4:0]       res_lost_ff;
   rsp_type          rsp_ff;

   logic             flag_we;
   logic [IDX_W-1:0] flag_wa;
   logic [1:0]       flag_wd;
   logic             seq_we;
   logic [IDX_W-1:0] addr_next, wr_next, mark_idx, max_next, end_idx;
   logic [SEC_W-1:0] sec_end;
   logic [31:0]      mark_wide;
   logic             is_valid, is_free;

   assign is_valid  = flag_q_ff == FLAG_VALID;
   assign is_free   = flag_q_ff == FLAG_EMPTY || flag_q_ff == FLAG_SENT;
   assign addr_next = (addr_ff == IDX_W'(SLOT_COUNT - 1)) ? '0 : addr_ff + 1'b1;
   assign wr_next   = addr_next;
   assign max_next  = (max_idx_ff == IDX_W'(SLOT_COUNT - 1)) ? '0 : max_idx_ff + 1'b1;
   assign mark_wide = 32'(mark_ff);
   assign mark_idx  = mark_wide[IDX_W-1:0];
   assign sec_end   = sec_base_ff + SEC_W'(SLOTS_PER_SECTOR);
   assign end_idx   = (sec_end >= SEC_W'(SLOT_COUNT)) ?
                      IDX_W'(sec_end - SEC_W'(SLOT_COUNT)) : IDX_W'(sec_end);

   always_comb begin
      flag_we = 1'b0;
      flag_wa = addr_ff;
      flag_wd = FLAG_EMPTY;
      seq_we  = 1'b0;
      case (cmd.op)
         OP_CLEAR_STEP, OP_ERASE_STEP: begin
            flag_we = 1'b1;
         end
         OP_PUSH_WRITE: begin
            flag_we = 1'b1;
            flag_wd = FLAG_VALID;
            seq_we  = 1'b1;
         end
         OP_MARK: begin
            flag_we = 1'b1;
            flag_wa = mark_idx;
            flag_wd = FLAG_SENT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flags_mem[flag_wa] <= flag_wd;
      end
      if (seq_we) begin
         seqs_mem[addr_ff] <= next_seq_ff;
      end
      flag_q_ff <= flags_mem[addr_ff];
      seq_q_ff  <= seqs_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b1;
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         total_ff    <= '0;
         next_seq_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            enabled_ff <= csr_wr_data;
         end
         case (cmd.op)
            OP_FORMAT: begin
               rd_ptr_ff   <= '0;
               wr_ptr_ff   <= '0;
               total_ff    <= '0;
               next_seq_ff <= '0;
            end
            OP_PUSH_WRITE: begin
               wr_ptr_ff   <= wr_next;
               next_seq_ff <= next_seq_ff + 1'b1;
               if (total_ff < TOT_W'(SLOT_COUNT)) begin
                  total_ff <= total_ff + 1'b1;
               end
            end
            OP_ERASE_FIX: begin
               total_ff  <= (total_ff >= TOT_W'(lost_ff)) ? total_ff - TOT_W'(lost_ff) : '0;
               rd_ptr_ff <= end_idx;
               wr_ptr_ff <= IDX_W'(sec_base_ff);
            end
            OP_RPTR_FOUND: begin
               rd_ptr_ff <= addr_ff;
            end
            OP_MARK: begin
               if (total_ff != '0) begin
                  total_ff <= total_ff - 1'b1;
               end
               rd_ptr_ff <= (mark_idx == IDX_W'(SLOT_COUNT - 1)) ? '0 : mark_idx + 1'b1;
            end
            OP_SCAN_FIN: begin
               total_ff <= vcount_ff;
               if (!have_valid_ff) begin
                  rd_ptr_ff   <= have_free_ff ? first_free_ff : '0;
                  wr_ptr_ff   <= have_free_ff ? first_free_ff : '0;
                  next_seq_ff <= '0;
               end else begin
                  rd_ptr_ff   <= min_idx_ff;
                  wr_ptr_ff   <= max_next;
                  next_seq_ff <= max_seq_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LATCH: begin
            opcode_ff     <= req_data.opcode;
            mark_ff       <= req_data.slot_to_mark;
            res_status_ff <= ST_DONE;
            res_slot_ff   <= '0;
            res_seq_ff    <= '0;
            res_lost_ff   <= '0;
         end
         OP_CLEAR_INIT, OP_FORMAT: begin
            addr_ff <= '0;
            cnt_ff  <= '0;
         end
         OP_CLEAR_STEP, OP_STEP: begin
            addr_ff <= addr_next;
            cnt_ff  <= cnt_ff + 1'b1;
         end
         OP_RES_DISABLED: res_status_ff <= ST_DISABLED;
         OP_RES_NONE:     res_status_ff <= ST_NONE;
         OP_PUSH_INIT: begin
            addr_ff <= wr_ptr_ff;
            cnt_ff  <= '0;
         end
         OP_PUSH_WRITE: begin
            res_slot_ff <= addr_ff;
            res_seq_ff  <= next_seq_ff;
         end
         OP_SEC_INIT: sec_base_ff <= '0;
         OP_SEC_STEP: sec_base_ff <= sec_end;
         OP_ERASE_INIT: begin
            addr_ff <= IDX_W'(sec_base_ff);
            cnt_ff  <= '0;
            lost_ff <= '0;
         end
         OP_ERASE_STEP: begin
            addr_ff <= addr_next;
            cnt_ff  <= cnt_ff + 1'b1;
            if (is_valid) begin
               lost_ff <= lost_ff + 1'b1;
            end
         end
         OP_ERASE_FIX: begin
            addr_ff     <= end_idx;
            cnt_ff      <= '0;
            res_lost_ff <= (lost_ff > LOST_W'(31)) ? 5'd31 : 5'(lost_ff);
         end
         OP_RPTR_FOUND, OP_ADDR_WR: addr_ff <= wr_ptr_ff;
         OP_PEEK_INIT: begin
            addr_ff <= rd_ptr_ff;
            cnt_ff  <= '0;
         end
         OP_PEEK_FOUND: begin
            res_status_ff <= ST_FOUND;
            res_slot_ff   <= addr_ff;
            res_seq_ff    <= seq_q_ff;
         end
         OP_PEEK_MISS: res_status_ff <= ST_NONE;
         OP_MARK:      res_slot_ff   <= mark_idx;
         OP_SCAN_INIT: begin
            addr_ff       <= '0;
            cnt_ff        <= '0;
            vcount_ff     <= '0;
            have_valid_ff <= 1'b0;
            have_free_ff  <= 1'b0;
            first_free_ff <= '0;
         end
         OP_SCAN_STEP: begin
            addr_ff <= addr_next;
            cnt_ff  <= cnt_ff + 1'b1;
            if (is_valid) begin
               vcount_ff <= vcount_ff + 1'b1;
               if (!have_valid_ff) begin
                  have_valid_ff <= 1'b1;
                  min_seq_ff    <= seq_q_ff;
                  min_idx_ff    <= addr_ff;
                  max_seq_ff    <= seq_q_ff;
                  max_idx_ff    <= addr_ff;
               end else begin
                  if (seq_q_ff < min_seq_ff) begin
                     min_seq_ff <= seq_q_ff;
                     min_idx_ff <= addr_ff;
                  end
                  if (seq_q_ff > max_seq_ff) begin
                     max_seq_ff <= seq_q_ff;
                     max_idx_ff <= addr_ff;
                  end
               end
            end
            if (is_free && !have_free_ff) begin
               have_free_ff  <= 1'b1;
               first_free_ff <= addr_ff;
            end
         end
         OP_LOAD: begin
            rsp_ff.status          <= res_status_ff;
            rsp_ff.slot_index      <= 12'(res_slot_ff);
            rsp_ff.record_sequence <= res_seq_ff;
            rsp_ff.lost_records    <= res_lost_ff;
            rsp_ff.pending_count   <= (total_ff > TOT_W'(8191)) ? 13'd8191 : 13'(total_ff);
            rsp_ff.read_pointer    <= 12'(rd_ptr_ff);
            rsp_ff.write_pointer   <= 12'(wr_ptr_ff);
         end
         default: begin
         end
      endcase
   end

   assign rsp_data = rsp_ff;

   always_comb begin
      sts.enabled    = enabled_ff;
      sts.opcode     = opcode_ff;
      sts.mark_ok    = mark_wide < 32'(SLOT_COUNT);
      sts.total_zero = total_ff == '0;
      sts.flag_free  = is_free;
      sts.flag_valid = is_valid;
      sts.walk_last  = cnt_ff == IDX_W'(SLOT_COUNT - 1);
      sts.erase_last = cnt_ff == IDX_W'(SLOTS_PER_SECTOR - 1) ||
                       addr_ff == IDX_W'(SLOT_COUNT - 1);
      sts.sec_below  = SEC_W'(rd_ptr_ff) >= sec_end;
   end

endmodule

// ===== rtl/frrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// frrm_ctrl
// Sequencer that walks the slot memories and handles both handshakes.
// ----------------------------------------------------------------------------
module frrm_ctrl import frrm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      S_CLEAR_INIT, S_CLEAR, S_IDLE, S_DECODE,
      S_PUSH_RD, S_PUSH_EV, S_SEC_FIND, S_ERASE_RD, S_ERASE_EV, S_ERASE_FIX,
      S_RPTR_CHECK, S_RPTR_RD, S_RPTR_EV, S_PUSH_STORE,
      S_PEEK_RD, S_PEEK_EV, S_SCAN_START, S_SCAN_RD, S_SCAN_EV, S_SCAN_FIN,
      S_FMT_CLEAR, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, rsp_valid_ff;
   dp_op_type op;

   always_comb begin
      state_in = state_ff;
      op       = OP_NOP;
      case (state_ff)
         S_CLEAR_INIT: begin
            op       = OP_CLEAR_INIT;
            state_in = S_CLEAR;
         end
         S_CLEAR: begin
            op = OP_CLEAR_STEP;
            if (sts.walk_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            if (!sts.enabled) begin
               op = OP_RES_DISABLED;
            end else begin
               case (sts.opcode)
                  OPC_PUSH: begin
                     op       = OP_PUSH_INIT;
                     state_in = S_PUSH_RD;
                  end
                  OPC_PEEK: begin
                     if (sts.total_zero) begin
                        op = OP_RES_NONE;
                     end else begin
                        op       = OP_PEEK_INIT;
                        state_in = S_PEEK_RD;
                     end
                  end
                  OPC_MARK: begin
                     if (sts.mark_ok) op = OP_MARK;
                  end
                  OPC_FORMAT: begin
                     op       = OP_FORMAT;
                     state_in = S_FMT_CLEAR;
                  end
                  OPC_RESCAN: begin
                     op       = OP_SCAN_INIT;
                     state_in = S_SCAN_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PUSH_RD: state_in = S_PUSH_EV;
         S_PUSH_EV: begin
            if (sts.flag_free) begin
               op       = OP_PUSH_WRITE;
               state_in = S_DONE;
            end else if (sts.walk_last) begin
               op       = OP_SEC_INIT;
               state_in = S_SEC_FIND;
            end else begin
               op       = OP_STEP;
               state_in = S_PUSH_RD;
            end
         end
         S_SEC_FIND: begin
            if (sts.sec_below) begin
               op = OP_SEC_STEP;
            end else begin
               op       = OP_ERASE_INIT;
               state_in = S_ERASE_RD;
            end
         end
         S_ERASE_RD: state_in = S_ERASE_EV;
         S_ERASE_EV: begin
            op       = OP_ERASE_STEP;
            state_in = sts.erase_last ? S_ERASE_FIX : S_ERASE_RD;
         end
         S_ERASE_FIX: begin
            op       = OP_ERASE_FIX;
            state_in = S_RPTR_CHECK;
         end
         S_RPTR_CHECK: begin
            if (sts.total_zero) begin
               op       = OP_ADDR_WR;
               state_in = S_PUSH_STORE;
            end else begin
               state_in = S_RPTR_RD;
            end
         end
         S_RPTR_RD: state_in = S_RPTR_EV;
         S_RPTR_EV: begin
            if (sts.flag_valid) begin
               op       = OP_RPTR_FOUND;
               state_in = S_PUSH_STORE;
            end else if (sts.walk_last) begin
               op       = OP_ADDR_WR;
               state_in = S_PUSH_STORE;
            end else begin
               op       = OP_STEP;
               state_in = S_RPTR_RD;
            end
         end
         S_PUSH_STORE: begin
            op       = OP_PUSH_WRITE;
            state_in = S_DONE;
         end
         S_PEEK_RD: state_in = S_PEEK_EV;
         S_PEEK_EV: begin
            if (sts.flag_valid) begin
               op       = OP_PEEK_FOUND;
               state_in = S_DONE;
            end else if (sts.walk_last) begin
               op       = OP_PEEK_MISS;
               state_in = S_SCAN_START;
            end else begin
               op       = OP_STEP;
               state_in = S_PEEK_RD;
            end
         end
         S_SCAN_START: begin
            op       = OP_SCAN_INIT;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: state_in = S_SCAN_EV;
         S_SCAN_EV: begin
            op       = OP_SCAN_STEP;
            state_in = sts.walk_last ? S_SCAN_FIN : S_SCAN_RD;
         end
         S_SCAN_FIN: begin
            op       = OP_SCAN_FIN;
            state_in = S_DONE;
         end
         S_FMT_CLEAR: begin
            op = OP_CLEAR_STEP;
            if (sts.walk_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               op       = OP_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR_INIT;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= state_in == S_IDLE;
         if (op == OP_LOAD) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign cmd.op    = op;

endmodule
